FILE: hw/rtl/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg: shared types and constants of the calendar tick counter
// Sub-step scaling, run limits, register reset values and the radix bundle.
// ----------------------------------------------------------------------------
package ctc_pkg;

    // Sub-steps that make one whole step
    localparam int SUBSTEP_SCALE = 100;
    // Cap on steps taken for one input word
    localparam int MAX_STEPS     = 64;

    localparam int ELAPSED_W   = 13;
    localparam int TOTAL_W     = ELAPSED_W + 1;
    localparam int ACC_W       = 7;
    localparam int STEP_CNT_W  = 7;
    localparam int RADIX_W     = 8;
    localparam int YEAR_W      = 16;
    localparam int MINUTE_W    = 6;
    localparam int MIN_PER_HR  = 60;

    // Depth of the run queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [RADIX_W-1:0] STEP_RADIX_RST  = 8'd48;
    localparam logic [RADIX_W-1:0] HOUR_RADIX_RST  = 8'd24;
    localparam logic [RADIX_W-1:0] DAY_RADIX_RST   = 8'd30;
    localparam logic [RADIX_W-1:0] MONTH_RADIX_RST = 8'd12;

    // Radix set handed from the register bank to the back end
    typedef struct packed {
        logic [RADIX_W-1:0] step_radix;
        logic [RADIX_W-1:0] hour_radix;
        logic [RADIX_W-1:0] day_radix;
        logic [RADIX_W-1:0] month_radix;
    } cfg_t;

endpackage

FILE: hw/rtl/ctc_queue.sv
// ----------------------------------------------------------------------------
// ctc_queue: small register queue
// Holds step counts of pending runs between the front and the back end.
// DEPTH must be 2 or more.
// ----------------------------------------------------------------------------
module ctc_queue
    import ctc_pkg::*;
#(
    parameter int WIDTH = STEP_CNT_W,
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             q_full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             q_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hw/rtl/ctc_front.sv
// ----------------------------------------------------------------------------
// ctc_front: sub-step accumulation and step count
// Adds each input word to the sub-step accumulator, splits the sum into
// whole steps and remainder with a reciprocal multiply followed by a
// multiply-subtract, caps the run and queues the step count.
// ----------------------------------------------------------------------------
module ctc_front
    import ctc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [ELAPSED_W-1:0]  elapsed_substeps,
    output logic                  run_push,
    output logic [STEP_CNT_W-1:0] run_steps,
    input  logic                  run_full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_REM  = 2'd2;
    localparam logic [1:0] F_DONE = 2'd3;

    // Rounded-up reciprocal of the step size; exact for every reachable sum
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + SUBSTEP_SCALE - 1) / SUBSTEP_SCALE;
    localparam int PROD_W      = TOTAL_W + RECIP_SHIFT + 1;

    logic [1:0]         state_reg, state_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [TOTAL_W-1:0] dvd_reg, dvd_next;
    logic [TOTAL_W-1:0] quot_reg, quot_next;
    logic [ACC_W-1:0]   rem_reg, rem_next;
    logic [TOTAL_W-1:0] total;
    logic [PROD_W-1:0]  prod;
    logic [TOTAL_W-1:0] rem_full;

    assign full     = (state_reg != F_IDLE);
    assign total    = {1'b0, elapsed_substeps} + TOTAL_W'(acc_reg);
    assign prod     = PROD_W'(dvd_reg) * PROD_W'(RECIP_MULT);
    assign rem_full = dvd_reg - quot_reg * TOTAL_W'(SUBSTEP_SCALE);

    // Cap the run length
    assign run_steps = (quot_reg > TOTAL_W'(MAX_STEPS)) ? STEP_CNT_W'(MAX_STEPS)
                                                       : quot_reg[STEP_CNT_W-1:0];
    assign run_push  = (state_reg == F_DONE) && (run_steps != '0);

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        dvd_next   = dvd_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                // Take the word and hold the sum
                if (push)
                begin
                    dvd_next   = total;
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                // Whole steps by reciprocal multiplication
                quot_next  = prod[RECIP_SHIFT +: TOTAL_W];
                state_next = F_REM;
            end
            F_REM:
            begin
                // Sub-steps left below one step
                rem_next   = rem_full[ACC_W-1:0];
                state_next = F_DONE;
            end
            F_DONE:
            begin
                // Hold until the queue has room, keep the remainder
                if ((run_steps == '0) || !run_full)
                begin
                    acc_next   = rem_reg;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

endmodule

FILE: hw/rtl/ctc_back.sv
// ----------------------------------------------------------------------------
// ctc_back: calendar counters and result register
// Takes one queued run, advances the calendar step by step, works out the
// minute with a shift-subtract divider and hands each result to the output.
// ----------------------------------------------------------------------------
module ctc_back
    import ctc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  run_empty,
    input  logic [STEP_CNT_W-1:0] run_steps,
    output logic                  run_pop,
    output logic                  empty,
    input  logic                  pop,
    output logic [MINUTE_W-1:0]   minute,
    output logic [RADIX_W-1:0]    hour,
    output logic [RADIX_W-1:0]    day,
    output logic [RADIX_W-1:0]    month,
    output logic [YEAR_W-1:0]     year,
    output logic                  hour_tick,
    output logic                  day_tick,
    output logic                  year_tick,
    output logic                  last_of_run
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_STEP = 2'd1;
    localparam logic [1:0] B_DIV  = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    localparam int PROD_W  = RADIX_W + MINUTE_W;
    localparam int QBIT_W  = $clog2(MINUTE_W);

    logic [1:0]            state_reg, state_next;
    logic [STEP_CNT_W-1:0] left_reg, left_next;
    logic [RADIX_W-1:0]    sih_reg, sih_next;
    logic [RADIX_W-1:0]    hr_reg, hr_next;
    logic [RADIX_W-1:0]    dy_reg, dy_next;
    logic [RADIX_W-1:0]    mo_reg, mo_next;
    logic [YEAR_W-1:0]     yr_reg, yr_next;
    logic                  ht_reg, ht_next;
    logic                  dt_reg, dt_next;
    logic                  yt_reg, yt_next;
    logic [PROD_W-1:0]     drem_reg, drem_next;
    logic [MINUTE_W-1:0]   dq_reg, dq_next;
    logic [QBIT_W-1:0]     dbit_reg, dbit_next;

    logic                  out_valid_reg, out_valid_next;
    logic [MINUTE_W-1:0]   o_min_reg;
    logic [RADIX_W-1:0]    o_hr_reg, o_dy_reg, o_mo_reg;
    logic [YEAR_W-1:0]     o_yr_reg;
    logic                  o_ht_reg, o_dt_reg, o_yt_reg, o_last_reg;
    logic                  out_load;

    logic [RADIX_W:0]      sih_inc, hr_inc, dy_inc, mo_inc;
    logic                  h_roll, d_roll, m_roll, y_roll;
    logic [RADIX_W-1:0]    sih_new;
    logic [PROD_W-1:0]     dvsr;
    logic                  dfits;
    logic [MINUTE_W-1:0]   minute_val;

    assign empty       = !out_valid_reg;
    assign minute      = o_min_reg;
    assign hour        = o_hr_reg;
    assign day         = o_dy_reg;
    assign month       = o_mo_reg;
    assign year        = o_yr_reg;
    assign hour_tick   = o_ht_reg;
    assign day_tick    = o_dt_reg;
    assign year_tick   = o_yt_reg;
    assign last_of_run = o_last_reg;

    assign run_pop = (state_reg == B_IDLE) && !run_empty;

    // Cascade of rollovers for one step
    assign sih_inc = {1'b0, sih_reg} + 1'b1;
    assign hr_inc  = {1'b0, hr_reg} + 1'b1;
    assign dy_inc  = {1'b0, dy_reg} + 1'b1;
    assign mo_inc  = {1'b0, mo_reg} + 1'b1;
    assign h_roll  = (sih_inc >= {1'b0, cfg.step_radix});
    assign d_roll  = h_roll && (hr_inc >= {1'b0, cfg.hour_radix});
    assign m_roll  = d_roll && (dy_inc >= {1'b0, cfg.day_radix});
    assign y_roll  = m_roll && (mo_inc >= {1'b0, cfg.month_radix});
    assign sih_new = h_roll ? '0 : sih_inc[RADIX_W-1:0];

    // Minute divider: trial subtract of the radix shifted to the current bit
    assign dvsr  = PROD_W'(cfg.step_radix) << dbit_reg;
    assign dfits = (drem_reg >= dvsr);

    // A zero radix reads as one: the minute is then zero
    assign minute_val = (cfg.step_radix == '0) ? '0 : dq_reg;

    assign out_load = (state_reg == B_OUT) && (!out_valid_reg || pop);

    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        sih_next   = sih_reg;
        hr_next    = hr_reg;
        dy_next    = dy_reg;
        mo_next    = mo_reg;
        yr_next    = yr_reg;
        ht_next    = ht_reg;
        dt_next    = dt_reg;
        yt_next    = yt_reg;
        drem_next  = drem_reg;
        dq_next    = dq_reg;
        dbit_next  = dbit_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                // Take the next run
                if (!run_empty)
                begin
                    left_next  = run_steps;
                    state_next = B_STEP;
                end
            end
            B_STEP:
            begin
                // Advance the calendar by one step
                sih_next = sih_new;
                if (h_roll)
                begin
                    hr_next = d_roll ? '0 : hr_inc[RADIX_W-1:0];
                end
                if (d_roll)
                begin
                    dy_next = m_roll ? '0 : dy_inc[RADIX_W-1:0];
                end
                if (m_roll)
                begin
                    mo_next = y_roll ? '0 : mo_inc[RADIX_W-1:0];
                end
                if (y_roll)
                begin
                    yr_next = yr_reg + 1'b1;
                end
                ht_next    = h_roll;
                dt_next    = d_roll;
                yt_next    = y_roll;
                drem_next  = PROD_W'(sih_new) * PROD_W'(MIN_PER_HR);
                dq_next    = '0;
                dbit_next  = QBIT_W'(MINUTE_W - 1);
                state_next = B_DIV;
            end
            B_DIV:
            begin
                // One minute bit per cycle, most significant first
                dq_next = {dq_reg[MINUTE_W-2:0], dfits};
                if (dfits)
                begin
                    drem_next = drem_reg - dvsr;
                end
                dbit_next = dbit_reg - 1'b1;
                if (dbit_reg == '0)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                // Hand over the result once the output slot is free
                if (out_load)
                begin
                    left_next  = left_reg - 1'b1;
                    state_next = (left_reg == STEP_CNT_W'(1)) ? B_IDLE : B_STEP;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            left_reg      <= '0;
            sih_reg       <= '0;
            hr_reg        <= '0;
            dy_reg        <= '0;
            mo_reg        <= '0;
            yr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            sih_reg       <= sih_next;
            hr_reg        <= hr_next;
            dy_reg        <= dy_next;
            mo_reg        <= mo_next;
            yr_reg        <= yr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ht_reg   <= ht_next;
        dt_reg   <= dt_next;
        yt_reg   <= yt_next;
        drem_reg <= drem_next;
        dq_reg   <= dq_next;
        dbit_reg <= dbit_next;
    end

    // Capture the result word
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_min_reg  <= minute_val;
            o_hr_reg   <= hr_reg;
            o_dy_reg   <= dy_reg;
            o_mo_reg   <= mo_reg;
            o_yr_reg   <= yr_reg;
            o_ht_reg   <= ht_reg;
            o_dt_reg   <= dt_reg;
            o_yt_reg   <= yt_reg;
            o_last_reg <= (left_reg == STEP_CNT_W'(1));
        end
    end

endmodule

FILE: hw/rtl/calendar_tick_counter.sv
// ----------------------------------------------------------------------------
// calendar_tick_counter: step counter with hour, day, month and year rollover
// Input words carry elapsed sub-steps; one result word per step, 64 at most.
//
// Input side: push/full. A word is taken when push is high and full low.
// The front adds it to the sub-step accumulator, finds the whole steps by a
// reciprocal multiply and the remainder by a multiply-subtract in the next
// cycle; full stays high until the step count is queued, which waits while
// the queue of runs is full, so the front takes no new word before it is
// done with the last. Result side: empty/pop. The oldest result sits on the
// ports while empty is low and leaves when pop is high. Each step in the
// back end is a calendar update, the minute divider (most significant bit
// first) and a hand-over to the result register. A queue of step counts
// sits between front and back, so the front keeps taking words while
// earlier runs are played out. When pop stays low the back end holds its
// finished result and stops; the front then stops once the queue fills.
// Reset clears all counters and the accumulator and loads the radix
// registers with 48 steps per hour, 24 hours, 30 days and 12 months.
// Radix writes (cfg_we, cfg_index, cfg_data) take effect at once.
// ----------------------------------------------------------------------------
module calendar_tick_counter
    import ctc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [ELAPSED_W-1:0] elapsed_substeps,
    output logic                 empty,
    input  logic                 pop,
    output logic [MINUTE_W-1:0]  minute,
    output logic [RADIX_W-1:0]   hour,
    output logic [RADIX_W-1:0]   day,
    output logic [RADIX_W-1:0]   month,
    output logic [YEAR_W-1:0]    year,
    output logic                 hour_tick,
    output logic                 day_tick,
    output logic                 year_tick,
    output logic                 last_of_run,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [RADIX_W-1:0]   cfg_data
);

    localparam logic [1:0] REG_STEP_RADIX  = 2'd0;
    localparam logic [1:0] REG_HOUR_RADIX  = 2'd1;
    localparam logic [1:0] REG_DAY_RADIX   = 2'd2;
    localparam logic [1:0] REG_MONTH_RADIX = 2'd3;

    cfg_t                  cfg_reg;
    logic                  run_push;
    logic [STEP_CNT_W-1:0] run_steps_in;
    logic                  run_full;
    logic                  run_pop;
    logic [STEP_CNT_W-1:0] run_steps_out;
    logic                  run_empty;

    // Radix register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_radix  <= STEP_RADIX_RST;
            cfg_reg.hour_radix  <= HOUR_RADIX_RST;
            cfg_reg.day_radix   <= DAY_RADIX_RST;
            cfg_reg.month_radix <= MONTH_RADIX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEP_RADIX:  cfg_reg.step_radix  <= cfg_data;
                REG_HOUR_RADIX:  cfg_reg.hour_radix  <= cfg_data;
                REG_DAY_RADIX:   cfg_reg.day_radix   <= cfg_data;
                REG_MONTH_RADIX: cfg_reg.month_radix <= cfg_data;
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    ctc_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .elapsed_substeps (elapsed_substeps),
        .run_push         (run_push),
        .run_steps        (run_steps_in),
        .run_full         (run_full)
    );

    ctc_queue #(
        .WIDTH (STEP_CNT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (run_push),
        .wr_data (run_steps_in),
        .q_full  (run_full),
        .rd_en   (run_pop),
        .rd_data (run_steps_out),
        .q_empty (run_empty)
    );

    ctc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .run_empty   (run_empty),
        .run_steps   (run_steps_out),
        .run_pop     (run_pop),
        .empty       (empty),
        .pop         (pop),
        .minute      (minute),
        .hour        (hour),
        .day         (day),
        .month       (month),
        .year        (year),
        .hour_tick   (hour_tick),
        .day_tick    (day_tick),
        .year_tick   (year_tick),
        .last_of_run (last_of_run)
    );

endmodule
